/* design/acmac_pkg.sv */
`default_nettype none
package acmac_pkg;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYGEN,
    ST_LGEN,
    ST_MSG,
    ST_OUT
  } state_t;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;
  localparam logic [7:0] CMAC_RB  = 8'h87;
  localparam logic [7:0] CMAC_PAD = 8'h80;
  localparam int unsigned NUM_ROUNDS = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // gf(2^128) doubling
  function automatic logic [127:0] dbl(input logic [127:0] v);
    dbl = {v[126:0], 1'b0} ^ (v[127] ? {120'd0, CMAC_RB} : 128'd0);
  endfunction

endpackage
`default_nettype wire

/* design/aes_cmac_128_unit.sv */
`default_nettype none
// channel | ports                         | direction
// input   | in_valid, in_stall, in_word   | in
// result  | out_valid, out_stall, out_word| out
// config  | cfg_we, cfg_index, cfg_data   | in
// a word runs through the shared aes round unit (load, then 10 rounds) after its
// accept; the next word is taken only once the sequencer is back in idle
// after a key write, the first word first runs key expansion and then the computation of L
// a last word then passes through an output state that moves its tag into the output register
// the tag waits there until taken; in_stall stays high while a newer tag waits for it
// reset is synchronous, active low; it clears the state, the chain, the key registers, the key-ready flag and out_valid
module aes_cmac_128_unit import acmac_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [63:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [63:0]  key_hi_r, key_lo_r;
  logic         ready_r, ready_nxt;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] k1_r, k1_nxt, k2_r, k2_nxt;
  logic [127:0] rkgen_r, rkgen_nxt;
  logic [127:0] rk_mem [11];
  logic         rk_we;
  logic [127:0] rk_rd_r;
  logic         last_r, last_nxt;
  in_word_t     item_r, item_nxt;
  logic [127:0] rnd_out, rkey_out;
  logic [127:0] blk;
  logic [127:0] padm;
  logic         out_valid_r, out_valid_nxt;
  out_word_t    out_r, out_nxt;

  acmac_round u_round (
    .state_i(st_r), .key_i(rk_rd_r), .final_i(rnd_r == 4'(NUM_ROUNDS)),
    .rkey_i(rkgen_r), .rnd_i(rnd_r), .state_o(rnd_out), .rkey_o(rkey_out)
  );

  // round key memory, read registered at the next round's index so the key is ready in its round
  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rnd_r + 4'd1] <= rkey_out;
    end
    if (state_r == ST_KEYGEN && rnd_r == 4'd0) begin
      rk_mem[0] <= {key_hi_r, key_lo_r};
    end
    rk_rd_r <= rk_mem[rnd_nxt];
  end

  // padding of a short last block
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < item_r.valid_bytes) begin
        padm[127-8*i -: 8] = 8'hff;
      end else begin
        padm[127-8*i -: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    blk = {item_r.data_high, item_r.data_low};
    if (item_r.last) begin
      if (item_r.valid_bytes >= 5'd16) begin
        blk = blk ^ k1_r;
      end else begin
        blk = (blk & padm) ^ (128'(CMAC_PAD) << (8*(15 - 32'(item_r.valid_bytes[3:0]))))
              ^ k2_r;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    ready_nxt = ready_r;
    chain_nxt = chain_r;
    st_nxt = st_r;
    k1_nxt = k1_r;
    k2_nxt = k2_r;
    rkgen_nxt = rkgen_r;
    last_nxt = last_r;
    item_nxt = item_r;
    rk_we = 1'b0;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          item_nxt = in_word;
          rnd_nxt = 4'd0;
          if (!ready_r) begin
            state_nxt = ST_KEYGEN;
            rkgen_nxt = {key_hi_r, key_lo_r};
          end else begin
            state_nxt = ST_MSG;
            st_nxt = chain_r ^ {in_word.data_high, in_word.data_low};
            last_nxt = 1'b0;
          end
        end
      end
      ST_KEYGEN: begin
        rk_we = 1'b1;
        rnd_nxt = rnd_r + 4'd1;
        rkgen_nxt = rkey_out;
        if (rnd_r == 4'(NUM_ROUNDS - 1)) begin
          state_nxt = ST_LGEN;
          rnd_nxt = 4'd0;
          st_nxt = '0;
        end
      end
      ST_LGEN, ST_MSG: begin
        if (rnd_r == 4'd0) begin
          st_nxt = st_r ^ rk_rd_r;
          if (state_r == ST_MSG) begin
            st_nxt = (chain_r ^ blk) ^ rk_rd_r;
            last_nxt = item_r.last;
          end
          rnd_nxt = 4'd1;
        end else begin
          st_nxt = rnd_out;
          rnd_nxt = rnd_r + 4'd1;
          if (rnd_r == 4'(NUM_ROUNDS)) begin
            rnd_nxt = 4'd0;
            if (state_r == ST_LGEN) begin
              k1_nxt = dbl(rnd_out);
              k2_nxt = dbl(dbl(rnd_out));
              ready_nxt = 1'b1;
              state_nxt = ST_MSG;
            end else if (last_r) begin
              chain_nxt = '0;
              state_nxt = ST_OUT;
            end else begin
              chain_nxt = rnd_out;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_OUT: begin
        // tag sits in st_r until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt = st_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      ready_nxt = 1'b0;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r <= '0;
      ready_r <= 1'b0;
      chain_r <= '0;
      out_valid_r <= 1'b0;
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      ready_r <= ready_nxt;
      chain_r <= chain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_KEY_HIGH) begin
        key_hi_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_KEY_LOW) begin
        key_lo_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    k1_r <= k1_nxt;
    k2_r <= k2_nxt;
    rkgen_r <= rkgen_nxt;
    last_r <= last_nxt;
    item_r <= item_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r) else $error("tag dropped");
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= 4'(NUM_ROUNDS)) else $error("round count overrun");
  a_msg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MSG && !cfg_we && $past(!cfg_we)) |-> ready_r)
    else $error("message without keys");
`endif

endmodule
`default_nettype wire

/* design/acmac_round.sv */
`default_nettype none
module acmac_round import acmac_pkg::*; (
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] key_i,
  input  wire logic         final_i,
  input  wire logic [127:0] rkey_i,
  input  wire logic [3:0]   rnd_i,
  output logic      [127:0] state_o,
  output logic      [127:0] rkey_o
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] w [16];
  logic [7:0] k [16];
  logic [7:0] g [4];

  // sub bytes, shift rows, mix columns (skipped in the final round), add key
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
      k[i] = key_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = SBOX[s[((c+i)%4)*4+i]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[c*4]   = t[c*4]   ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3]) ^ xt(t[c*4]   ^ t[c*4+1]);
      m[c*4+1] = t[c*4+1] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3]) ^ xt(t[c*4+1] ^ t[c*4+2]);
      m[c*4+2] = t[c*4+2] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3]) ^ xt(t[c*4+2] ^ t[c*4+3]);
      m[c*4+3] = t[c*4+3] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3]) ^ xt(t[c*4+3] ^ t[c*4]);
    end
    for (int i = 0; i < 16; i++) begin
      state_o[127-8*i -: 8] = (final_i ? t[i] : m[i]) ^ k[i];
    end
  end

  // next round key from current one
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w[i] = rkey_i[127-8*i -: 8];
    end
    g[0] = SBOX[w[13]] ^ RCON[rnd_i];
    g[1] = SBOX[w[14]];
    g[2] = SBOX[w[15]];
    g[3] = SBOX[w[12]];
    for (int j = 0; j < 4; j++) begin
      rkey_o[127-8*j -: 8]      = w[j] ^ g[j];
      rkey_o[95-8*j -: 8]       = w[4+j] ^ w[j] ^ g[j];
      rkey_o[63-8*j -: 8]       = w[8+j] ^ w[4+j] ^ w[j] ^ g[j];
      rkey_o[31-8*j -: 8]       = w[12+j] ^ w[8+j] ^ w[4+j] ^ w[j] ^ g[j];
    end
  end

endmodule
`default_nettype wire
